// ----- hw/rtl/vsl_pkg.sv -----
// ----------------------------------------------------------------------------
// vsl_pkg: shared definitions for the velocity slew limiter
// Widths, time constants, register indexes and the structs that link the
// top level to its arithmetic lanes.
// ----------------------------------------------------------------------------
package vsl_pkg;

  // Field widths.
  localparam int VEL_WIDTH  = 16;
  localparam int TIME_WIDTH = 32;
  localparam int LIM_WIDTH  = VEL_WIDTH - 1;

  // A time step never exceeds the long-gap threshold, which fits in 19 bits.
  localparam int DT_WIDTH   = 19;
  localparam int PROD_WIDTH = LIM_WIDTH + DT_WIDTH;

  // The step is below 2^(LIM_WIDTH-1) because dt is at most half a second.
  localparam int STEP_WIDTH = LIM_WIDTH - 1;

  // Remainder of the division by one million stays below 2^20.
  localparam int REM_WIDTH  = 20;

  // Signed working width of the final select, with room for sums and negation.
  localparam int EXT_WIDTH  = VEL_WIDTH + 2;

  // Sequencing counter covers the longest serial phase.
  localparam int CNT_WIDTH  = $clog2(PROD_WIDTH);

  // Time constants in microseconds.
  localparam logic [TIME_WIDTH-1:0] GAP_US      = TIME_WIDTH'(500000);
  localparam logic [DT_WIDTH-1:0]   FALLBACK_US = DT_WIDTH'(100000);
  localparam logic [DT_WIDTH-1:0]   MIN_DT_US   = DT_WIDTH'(1);
  localparam logic [REM_WIDTH:0]    US_PER_S    = (REM_WIDTH + 1)'(1000000);

  // Configuration register file.
  localparam int NUM_REGS       = 7;
  localparam int REG_ADDR_WIDTH = 3;

  typedef enum logic [REG_ADDR_WIDTH-1:0] {
    REG_LIN_SPEED = 3'd0,
    REG_LIN_ACCEL = 3'd1,
    REG_LIN_DECEL = 3'd2,
    REG_ANG_SPEED = 3'd3,
    REG_ANG_ACCEL = 3'd4,
    REG_ANG_DECEL = 3'd5,
    REG_DEADBAND  = 3'd6
  } reg_index_t;

  localparam logic [LIM_WIDTH-1:0] RST_LIN_SPEED = LIM_WIDTH'(2048);
  localparam logic [LIM_WIDTH-1:0] RST_LIN_ACCEL = LIM_WIDTH'(2048);
  localparam logic [LIM_WIDTH-1:0] RST_LIN_DECEL = LIM_WIDTH'(10240);
  localparam logic [LIM_WIDTH-1:0] RST_ANG_SPEED = LIM_WIDTH'(4096);
  localparam logic [LIM_WIDTH-1:0] RST_ANG_ACCEL = LIM_WIDTH'(2048);
  localparam logic [LIM_WIDTH-1:0] RST_ANG_DECEL = LIM_WIDTH'(4096);
  localparam logic [LIM_WIDTH-1:0] RST_DEADBAND  = LIM_WIDTH'(41);

  // Phase controls from the sequencer to each lane.
  typedef struct packed {
    logic load;
    logic mul;
    logic div;
  } lane_ctrl_t;

  // Limits that apply to one channel.
  typedef struct packed {
    logic [LIM_WIDTH-1:0] vmax;
    logic [LIM_WIDTH-1:0] amax;
    logic [LIM_WIDTH-1:0] dmax;
    logic [LIM_WIDTH-1:0] thr;
  } lane_cfg_t;

endpackage

// ----- hw/rtl/vsl_lane.sv -----
// ----------------------------------------------------------------------------
// vsl_lane: one velocity channel of the slew limiter
// Forms limit*dt with a bit-serial shift-add multiplier, divides it by one
// million with a bit-serial restoring divider, then selects the output.
// ----------------------------------------------------------------------------
module vsl_lane import vsl_pkg::*; (
  input  logic                        clk,
  input  lane_ctrl_t                  ctrl,
  input  lane_cfg_t                   cfg,
  input  logic [DT_WIDTH-1:0]         dt,
  input  logic signed [VEL_WIDTH-1:0] cmd_in,
  input  logic signed [VEL_WIDTH-1:0] last_in,
  output logic signed [VEL_WIDTH-1:0] result
);

  // Operands held for the whole request.
  logic signed [VEL_WIDTH-1:0] cmd;
  logic signed [VEL_WIDTH-1:0] last;
  logic [LIM_WIDTH-1:0]        lim;

  // Serial arithmetic state.
  logic [DT_WIDTH-1:0]   dt_sh;
  logic [PROD_WIDTH-1:0] acc;
  logic [REM_WIDTH-1:0]  rem;
  logic [STEP_WIDTH-1:0] quo;

  logic signed [EXT_WIDTH-1:0] diff_in;
  logic                        rising;
  logic [REM_WIDTH:0]          trial;
  logic                        trial_ge;
  logic [PROD_WIDTH-1:0]       addend;

  // The sign of the raw change picks the acceleration or deceleration limit.
  assign diff_in = EXT_WIDTH'(cmd_in) - EXT_WIDTH'(last_in);
  assign rising  = diff_in > 0;

  assign addend   = dt_sh[DT_WIDTH-1] ? PROD_WIDTH'(lim) : '0;
  assign trial    = {rem, acc[PROD_WIDTH-1]};
  assign trial_ge = trial >= US_PER_S;

  // Load, then multiply MSB first over dt, then divide MSB first over the product.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd   <= cmd_in;
      last  <= last_in;
      lim   <= rising ? cfg.amax : cfg.dmax;
      dt_sh <= dt;
      acc   <= '0;
      rem   <= '0;
      quo   <= '0;
    end else if (ctrl.mul) begin
      acc   <= {acc[PROD_WIDTH-2:0], 1'b0} + addend;
      dt_sh <= {dt_sh[DT_WIDTH-2:0], 1'b0};
    end else if (ctrl.div) begin
      rem <= trial_ge ? REM_WIDTH'(trial - US_PER_S) : trial[REM_WIDTH-1:0];
      quo <= {quo[STEP_WIDTH-2:0], trial_ge};
      acc <= {acc[PROD_WIDTH-2:0], 1'b0};
    end
  end

  // Final selection once the step is known.
  logic signed [EXT_WIDTH-1:0] cmd_x;
  logic signed [EXT_WIDTH-1:0] last_x;
  logic signed [EXT_WIDTH-1:0] vmax_x;
  logic signed [EXT_WIDTH-1:0] thr_x;
  logic signed [EXT_WIDTH-1:0] step_x;
  logic signed [EXT_WIDTH-1:0] mag;
  logic signed [EXT_WIDTH-1:0] target;
  logic signed [EXT_WIDTH-1:0] diff;
  logic signed [EXT_WIDTH-1:0] moved;
  logic signed [EXT_WIDTH-1:0] moved_clamped;
  logic signed [EXT_WIDTH-1:0] chosen;
  logic                        bypass;
  logic                        limited;

  always_comb begin
    cmd_x  = EXT_WIDTH'(cmd);
    last_x = EXT_WIDTH'(last);
    vmax_x = EXT_WIDTH'(cfg.vmax);
    thr_x  = EXT_WIDTH'(cfg.thr);
    step_x = EXT_WIDTH'(quo);

    mag    = (cmd_x < 0) ? -cmd_x : cmd_x;
    bypass = mag <= thr_x;

    // Symmetric clamp of the command to the speed limit.
    if (cmd_x > vmax_x) begin
      target = vmax_x;
    end else if (cmd_x < -vmax_x) begin
      target = -vmax_x;
    end else begin
      target = cmd_x;
    end

    // The change is too fast when it exceeds floor(limit*dt/1e6).
    diff    = cmd_x - last_x;
    limited = ((diff > 0) && (diff > step_x)) || ((diff < 0) && (-diff > step_x));

    // Step from the last output toward the clamped target.
    moved = (target >= last_x) ? (last_x + step_x) : (last_x - step_x);
    if (moved > vmax_x) begin
      moved_clamped = vmax_x;
    end else if (moved < -vmax_x) begin
      moved_clamped = -vmax_x;
    end else begin
      moved_clamped = moved;
    end

    if (bypass) begin
      chosen = cmd_x;
    end else if (limited) begin
      chosen = moved_clamped;
    end else begin
      chosen = target;
    end
  end

  assign result = chosen[VEL_WIDTH-1:0];

endmodule

// ----- hw/rtl/velocity_slew_limiter.sv -----
// ----------------------------------------------------------------------------
// velocity_slew_limiter: rate and magnitude limiter for velocity commands
// Clamps linear and angular velocity commands to speed limits and bounds
// their rate of change over the time between timestamped requests.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one request per command: linear and angular
//   velocity (signed Q4.12) and a free-running microsecond timestamp. The
//   master channel returns one result per request: the limited velocities
//   and, in tuser, a flag that marks a history reset after a gap longer
//   than half a second.
//   Each request passes through the sequencer in order: the operands are
//   loaded at the accepting edge, then the limit is multiplied by dt
//   bit-serially, the product is divided by one million bit-serially,
//   and the result is posted to the output register. A new request is
//   accepted only after the current result has been posted. Both channels
//   run side by side in their own lanes.
//   A result waits in the output register while the receiver stalls; the
//   next request is accepted and worked on meanwhile, and it is held in the
//   lanes until the output register is free.
//   Reset loads the register defaults and clears the previous outputs and
//   timestamp. Limits are to be written through the config port only while
//   idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module velocity_slew_limiter import vsl_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // Slave request channel.
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // s_tdata: linear_cmd [15:0], angular_cmd [31:16], timestamp_us [63:32]
  input  logic [63:0]               s_tdata,
  // Master result channel.
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // m_tdata: linear_out [15:0], angular_out [31:16]
  output logic [31:0]               m_tdata,
  // m_tuser: history_reset [0]
  output logic [0:0]                m_tuser,
  // Configuration write port.
  input  logic                      cfg_we,
  input  logic [REG_ADDR_WIDTH-1:0] cfg_index,
  input  logic [LIM_WIDTH-1:0]      cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_POST
  } state_t;

  state_t               state;
  logic [CNT_WIDTH-1:0] cnt;

  // Configuration registers.
  logic [LIM_WIDTH-1:0] lin_speed;
  logic [LIM_WIDTH-1:0] lin_accel;
  logic [LIM_WIDTH-1:0] lin_decel;
  logic [LIM_WIDTH-1:0] ang_speed;
  logic [LIM_WIDTH-1:0] ang_accel;
  logic [LIM_WIDTH-1:0] ang_decel;
  logic [LIM_WIDTH-1:0] deadband;

  // History.
  logic signed [VEL_WIDTH-1:0] prev_linear;
  logic signed [VEL_WIDTH-1:0] prev_angular;
  logic [TIME_WIDTH-1:0]       prev_timestamp;

  // Output register.
  logic signed [VEL_WIDTH-1:0] out_linear;
  logic signed [VEL_WIDTH-1:0] out_angular;
  logic                        out_flag;
  logic                        gap_flag;

  // Request fields.
  logic signed [VEL_WIDTH-1:0] linear_cmd;
  logic signed [VEL_WIDTH-1:0] angular_cmd;
  logic [TIME_WIDTH-1:0]       timestamp_us;

  assign linear_cmd   = s_tdata[15:0];
  assign angular_cmd  = s_tdata[31:16];
  assign timestamp_us = s_tdata[63:32];

  logic accept;
  logic post;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign post     = (state == ST_POST) && (!m_tvalid || m_tready);

  // Time step with a floor of one microsecond and a fallback after a long gap.
  logic [TIME_WIDTH-1:0] udt;
  logic                  gap;
  logic [DT_WIDTH-1:0]   dt;

  assign udt = timestamp_us - prev_timestamp;
  assign gap = udt > GAP_US;

  always_comb begin
    priority if (udt == '0) begin
      dt = MIN_DT_US;
    end else if (gap) begin
      dt = FALLBACK_US;
    end else begin
      dt = udt[DT_WIDTH-1:0];
    end
  end

  // Lane control and limits.
  lane_ctrl_t ctrl;
  lane_cfg_t  lin_cfg;
  lane_cfg_t  ang_cfg;

  assign ctrl.load = accept;
  assign ctrl.mul  = (state == ST_MUL);
  assign ctrl.div  = (state == ST_DIV);

  assign lin_cfg = '{vmax: lin_speed, amax: lin_accel, dmax: lin_decel, thr: deadband};
  assign ang_cfg = '{vmax: ang_speed, amax: ang_accel, dmax: ang_decel, thr: deadband};

  logic signed [VEL_WIDTH-1:0] lin_last;
  logic signed [VEL_WIDTH-1:0] ang_last;
  logic signed [VEL_WIDTH-1:0] lin_result;
  logic signed [VEL_WIDTH-1:0] ang_result;

  // After a long gap the history restarts from the raw command.
  assign lin_last = gap ? linear_cmd : prev_linear;
  assign ang_last = gap ? angular_cmd : prev_angular;

  vsl_lane u_lin_lane (
    .clk     (clk),
    .ctrl    (ctrl),
    .cfg     (lin_cfg),
    .dt      (dt),
    .cmd_in  (linear_cmd),
    .last_in (lin_last),
    .result  (lin_result)
  );

  vsl_lane u_ang_lane (
    .clk     (clk),
    .ctrl    (ctrl),
    .cfg     (ang_cfg),
    .dt      (dt),
    .cmd_in  (angular_cmd),
    .last_in (ang_last),
    .result  (ang_result)
  );

  // Configuration writes; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      lin_speed <= RST_LIN_SPEED;
      lin_accel <= RST_LIN_ACCEL;
      lin_decel <= RST_LIN_DECEL;
      ang_speed <= RST_ANG_SPEED;
      ang_accel <= RST_ANG_ACCEL;
      ang_decel <= RST_ANG_DECEL;
      deadband  <= RST_DEADBAND;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIN_SPEED: lin_speed <= cfg_data;
        REG_LIN_ACCEL: lin_accel <= cfg_data;
        REG_LIN_DECEL: lin_decel <= cfg_data;
        REG_ANG_SPEED: ang_speed <= cfg_data;
        REG_ANG_ACCEL: ang_accel <= cfg_data;
        REG_ANG_DECEL: ang_decel <= cfg_data;
        REG_DEADBAND:  deadband  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer with history and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      cnt            <= '0;
      m_tvalid       <= 1'b0;
      prev_linear    <= '0;
      prev_angular   <= '0;
      prev_timestamp <= '0;
      gap_flag       <= 1'b0;
    end else begin
      // A new result fills the output register; a taken one frees it.
      if (post) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            prev_timestamp <= timestamp_us;
            gap_flag       <= gap;
            cnt            <= '0;
            state          <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (cnt == CNT_WIDTH'(DT_WIDTH - 1)) begin
            cnt   <= '0;
            state <= ST_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIV: begin
          if (cnt == CNT_WIDTH'(PROD_WIDTH - 1)) begin
            cnt   <= '0;
            state <= ST_POST;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_POST: begin
          if (post) begin
            prev_linear  <= lin_result;
            prev_angular <= ang_result;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (post) begin
      out_linear  <= lin_result;
      out_angular <= ang_result;
      out_flag    <= gap_flag;
    end
  end

  assign m_tdata = {out_angular, out_linear};
  assign m_tuser = out_flag;

endmodule
